>>> rtl/dep_pkg.sv
package dep_pkg;

  // Default sizes of the queue.
  localparam int unsigned CAPACITY_DEF  = 256;
  localparam int unsigned ID_BITS_DEF   = 20;
  localparam int unsigned PRIO_BITS_DEF = 24;
  localparam int unsigned STATUS_BITS   = 2;

  // Request codes; the fourth code is unused and ignored.
  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_POP_MAX = 2'd1,
    REQ_POP_MIN = 2'd2
  } req_e;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ins_we;
    logic    scan_start;
    logic    want_max;
    logic    seq_step;
    logic    shift_start;
    logic    pop_finish;
    logic    st_set;
    status_e st_val;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic seq_done;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/dep_ram.sv
module dep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/dep_datapath.sv
module dep_datapath
  import dep_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic [ID_BITS-1:0]     client_id_i,
  input  logic [PRIO_BITS-1:0]   prio_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ID_BITS-1:0]     served_id_o,
  output logic [STATUS_BITS-1:0] status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = ID_BITS + PRIO_BITS;

  logic [CW-1:0]        cnt_q, rd_idx_q;
  logic [AW-1:0]        data_idx_q, best_idx_q;
  logic                 rd_vld_q, have_best_q, want_max_q, shift_mode_q;
  logic [PRIO_BITS-1:0] best_prio_q;
  logic [ID_BITS-1:0]   best_id_q;
  status_e              pend_st_q;
  logic                 out_valid_q;
  logic [ID_BITS-1:0]   out_id_q;
  status_e              out_st_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata, ram_rdata;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [ID_BITS-1:0]   rd_id;
  logic                 better;

  dep_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_prio = ram_rdata[PRIO_BITS-1:0];
  assign rd_id   = ram_rdata[EW-1:PRIO_BITS];

  // Strict compare keeps the oldest entry on ties.
  assign better = !have_best_q ||
                  (want_max_q ? (rd_prio > best_prio_q) : (rd_prio < best_prio_q));

  // Write port: an insert at the tail, or one step of closing the gap.
  always_comb begin
    if (cmd_i.ins_we) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = {client_id_i, prio_value_i};
    end else begin
      ram_we    = rd_vld_q && shift_mode_q;
      ram_waddr = data_idx_q - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  assign stat_o.full     = (cnt_q == CW'(CAPACITY));
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.seq_done = (rd_idx_q == cnt_q) && !rd_vld_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.ins_we) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.pop_finish) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // Read sequencer shared by the scan and the shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      shift_mode_q <= 1'b0;
      have_best_q  <= 1'b0;
      want_max_q   <= 1'b0;
    end else if (cmd_i.scan_start) begin
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      shift_mode_q <= 1'b0;
      have_best_q  <= 1'b0;
      want_max_q   <= cmd_i.want_max;
    end else if (cmd_i.shift_start) begin
      rd_idx_q     <= CW'(best_idx_q) + CW'(1);
      rd_vld_q     <= 1'b0;
      shift_mode_q <= 1'b1;
    end else if (cmd_i.seq_step) begin
      if (rd_idx_q != cnt_q) begin
        rd_idx_q <= rd_idx_q + CW'(1);
        rd_vld_q <= 1'b1;
      end else begin
        rd_vld_q <= 1'b0;
      end
      if (rd_vld_q && !shift_mode_q && better) begin
        have_best_q <= 1'b1;
      end
    end
  end

  // Scan payload: index of the issued read and the best entry so far.
  always_ff @(posedge clk_i) begin
    if (cmd_i.seq_step) begin
      data_idx_q <= rd_idx_q[AW-1:0];
      if (rd_vld_q && !shift_mode_q && better) begin
        best_idx_q  <= data_idx_q;
        best_prio_q <= rd_prio;
        best_id_q   <= rd_id;
      end
    end
  end

  // Pending status of the request in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.st_set) begin
      pend_st_q <= cmd_i.st_val;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_st_q <= pend_st_q;
      out_id_q <= (pend_st_q == ST_OK) ? best_id_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign served_id_o = out_id_q;
  assign status_o    = out_st_q;

endmodule

>>> rtl/dep_ctrl.sv
module dep_ctrl
  import dep_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st_val = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_INSERT: begin
              if (stat_i.full) begin
                cmd_o.st_set = 1'b1;
                cmd_o.st_val = ST_FULL;
                state_d      = S_RESP;
              end else begin
                cmd_o.ins_we = 1'b1;
              end
            end
            REQ_POP_MAX, REQ_POP_MIN: begin
              if (stat_i.empty) begin
                cmd_o.st_set = 1'b1;
                cmd_o.st_val = ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                cmd_o.scan_start = 1'b1;
                cmd_o.want_max   = (req_type_i == REQ_POP_MAX);
                state_d          = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.seq_done) begin
          cmd_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end else begin
          cmd_o.seq_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat_i.seq_done) begin
          cmd_o.pop_finish = 1'b1;
          cmd_o.st_set     = 1'b1;
          cmd_o.st_val     = ST_OK;
          state_d          = S_RESP;
        end else begin
          cmd_o.seq_step = 1'b1;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/double_ended_priority_queue.sv
// Channel   Handshake              Payload
// request   in_valid_i/in_ready_o  req_type_i, client_id_i, prio_value_i
// result    out_valid_o/out_ready_i served_id_o, status_o
//
// An insert that fits is written in its accept cycle; the next request may follow at once.
// A pop scans all N stored entries through the single RAM read port,
// then closes the gap by moving the younger entries down.
// Full and empty answers skip the scan and go straight to the result state.
// Reset clears the count and the control state; the RAM needs no clearing.
// A held result stalls only requests that produce a result.
module double_ended_priority_queue
  import dep_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             req_type_i,
  input  logic [ID_BITS-1:0]     client_id_i,
  input  logic [PRIO_BITS-1:0]   prio_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ID_BITS-1:0]     served_id_o,
  output logic [STATUS_BITS-1:0] status_o
);

  cmd_t  cmd;
  stat_t stat;

  dep_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .req_type_i(req_type_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  dep_datapath #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .PRIO_BITS(PRIO_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .client_id_i (client_id_i),
    .prio_value_i(prio_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .served_id_o (served_id_o),
    .status_o    (status_o)
  );

  // A result that is not a served entry carries a zero id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> served_id_o == '0)
    else $error("non-ok result carries an id");

  // An insert into a full queue must not write and must lead to a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_INSERT) && stat.full
    |-> !cmd.ins_we ##1 !in_ready_o)
    else $error("insert into full queue was stored");

  // At most one of the sequencer, insert and output-load commands at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.scan_start, cmd.shift_start, cmd.seq_step, cmd.load_out, cmd.ins_we}))
    else $error("conflicting datapath commands");

endmodule
